/* src/frame_sequence_duplicate_filter_top_defines.svh */
// assertion macros for the frame sequence duplicate filter
// used by frame_sequence_duplicate_filter_top, no other dependencies
`ifndef FRAME_SEQUENCE_DUPLICATE_FILTER_TOP_DEFINES_SVH
`define FRAME_SEQUENCE_DUPLICATE_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FSDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FSDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/fsdf_pkg.sv */
// shared constants and types for the frame sequence duplicate filter
// no dependencies
package fsdf_pkg;

   // sequence space and bitmap geometry
   localparam int SEQ_W         = 16;
   localparam int SEQ_SPACE     = 64 * 1024;
   localparam int MAP_WORD_BITS = 64;
   localparam int CLEAR_SPAN    = 8 * 1024;
   localparam int WINDOW_SPAN   = 16 * 1024;

   localparam int MAP_WORDS   = SEQ_SPACE / MAP_WORD_BITS;
   localparam int BIT_W       = $clog2(MAP_WORD_BITS);
   localparam int ADDR_W      = $clog2(MAP_WORDS);
   localparam int CLEAR_WORDS = CLEAR_SPAN / MAP_WORD_BITS;
   localparam int CLR_CNT_W   = (CLEAR_WORDS > 1) ? $clog2(CLEAR_WORDS) : 1;

   // field widths
   localparam int LEN_W    = 14;
   localparam int OFF_W    = 5;
   localparam int STATUS_W = 2;

   // header decode
   localparam logic [SEQ_W-1:0] TAG_ETHERTYPE  = 16'hF1C1;
   localparam logic [SEQ_W-1:0] VLAN_ETHERTYPE = 16'h8100;
   localparam logic [OFF_W-1:0] TAG_HLEN       = 5'd20;
   localparam logic [OFF_W-1:0] VLAN_TAG_HLEN  = 5'd24;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_FORWARD    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_TAGGED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAYLOAD = 2'd3;

   // decoded header handed from the classifier to the control
   typedef struct packed {
      logic             has_tag;
      logic [OFF_W-1:0] hlen;
      logic [SEQ_W-1:0] seq;
   } parse_type;

endpackage

/* src/fsdf_classify.sv */
// header classifier: finds the redundancy tag and pulls out the sequence number
// depends on fsdf_pkg
module fsdf_classify (
   input  logic [fsdf_pkg::SEQ_W-1:0] outer_ethertype,
   input  logic [fsdf_pkg::SEQ_W-1:0] word_at_sixteen,
   input  logic [fsdf_pkg::SEQ_W-1:0] word_at_twenty,
   output fsdf_pkg::parse_type        parse
);

   always_comb begin
      parse = '0;
      if (outer_ethertype == fsdf_pkg::VLAN_ETHERTYPE) begin
         if (word_at_sixteen == fsdf_pkg::TAG_ETHERTYPE) begin
            parse.has_tag = 1'b1;
            parse.hlen    = fsdf_pkg::VLAN_TAG_HLEN;
            parse.seq     = word_at_twenty;
         end
      end else if (outer_ethertype == fsdf_pkg::TAG_ETHERTYPE) begin
         parse.has_tag = 1'b1;
         parse.hlen    = fsdf_pkg::TAG_HLEN;
         parse.seq     = word_at_sixteen;
      end
   end

endmodule

/* src/fsdf_seen_ram.sv */
// seen map storage: one write port, one read port with registered data
// depends on fsdf_pkg
module fsdf_seen_ram (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [fsdf_pkg::ADDR_W-1:0]         rd_addr,
   output logic [fsdf_pkg::MAP_WORD_BITS-1:0]  rd_data,
   input  logic                                wr_en,
   input  logic [fsdf_pkg::ADDR_W-1:0]         wr_addr,
   input  logic [fsdf_pkg::MAP_WORD_BITS-1:0]  wr_data
);

   logic [fsdf_pkg::MAP_WORD_BITS-1:0] mem [fsdf_pkg::MAP_WORDS];
   logic [fsdf_pkg::MAP_WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/frame_sequence_duplicate_filter_top.sv */
// frame sequence duplicate filter, top level with control sequencer
// depends on fsdf_pkg, fsdf_classify, fsdf_seen_ram and the assertion macro header
`include "frame_sequence_duplicate_filter_top_defines.svh"

// One header beat is taken when start is high and busy is low. Each beat gives
// exactly one result beat, shown on the rsp_ ports for a single cycle with
// rsp_strobe high; the receiver cannot stall, so it must take every result
// beat when it appears. An item runs accept -> read -> lookup, so busy is high
// through the read and lookup states and the next beat can go in once the
// sequencer is back in idle; the result is registered and shows in the cycle
// after the lookup. The seen map lives in a 1024 x 64 single-read, single-write
// RAM; each item reads one map word and writes it back with its bit set when
// the sequence number is new. When a new sequence number pushes the window
// forward, the sequencer walks the 128 words at the old window start, clearing
// one word per cycle, with busy high until the walk ends. After reset the whole
// map is zeroed one word per cycle, busy high, before the first beat can be accepted.
module frame_sequence_duplicate_filter_top (
   input  logic                               clock,
   input  logic                               reset,

   // request beat
   input  logic                               start,
   output logic                               busy,
   input  logic [fsdf_pkg::SEQ_W-1:0]         req_outer_ethertype,
   input  logic [fsdf_pkg::SEQ_W-1:0]         req_word_at_sixteen,
   input  logic [fsdf_pkg::SEQ_W-1:0]         req_word_at_twenty,
   input  logic [fsdf_pkg::LEN_W-1:0]         req_frame_length,

   // result beat
   output logic                               rsp_strobe,
   output logic [fsdf_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fsdf_pkg::OFF_W-1:0]         rsp_payload_offset,
   output logic [fsdf_pkg::LEN_W-1:0]         rsp_payload_length,
   output logic [fsdf_pkg::SEQ_W-1:0]         rsp_sequence_seen
);

   // sequencer states
   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,   // zeroing the map after reset
      ST_IDLE   = 5'b00010,   // waiting for a beat
      ST_READ   = 5'b00100,   // map word read issued
      ST_LOOKUP = 5'b01000,   // word back, test and write back
      ST_CLEAR  = 5'b10000    // clearing the words at the window start
   } state_type;

   state_type                            state_ff, state_in;
   logic [fsdf_pkg::ADDR_W-1:0]          init_cnt_ff, init_cnt_in;
   logic [fsdf_pkg::CLR_CNT_W-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [fsdf_pkg::SEQ_W-1:0]           window_start_ff, window_start_in;

   // item under work (payload, no reset)
   fsdf_pkg::parse_type                  parse_ff, parse_in;
   fsdf_pkg::parse_type                  parse_new;
   logic [fsdf_pkg::LEN_W-1:0]           len_ff, len_in;
   logic                                 advance_ff, advance_in;

   // result registers
   logic                                 rsp_strobe_ff, rsp_strobe_in;
   logic [fsdf_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [fsdf_pkg::OFF_W-1:0]           rsp_offset_ff, rsp_offset_in;
   logic [fsdf_pkg::LEN_W-1:0]           rsp_length_ff, rsp_length_in;
   logic [fsdf_pkg::SEQ_W-1:0]           rsp_seq_ff, rsp_seq_in;

   // map port signals
   logic                                 ram_rd_en;
   logic [fsdf_pkg::ADDR_W-1:0]          ram_rd_addr;
   logic [fsdf_pkg::MAP_WORD_BITS-1:0]   ram_rd_data;
   logic                                 ram_wr_en;
   logic [fsdf_pkg::ADDR_W-1:0]          ram_wr_addr;
   logic [fsdf_pkg::MAP_WORD_BITS-1:0]   ram_wr_data;

   // lookup helpers
   logic                                 accept;
   logic [fsdf_pkg::ADDR_W-1:0]          seq_word;
   logic [fsdf_pkg::BIT_W-1:0]           seq_bit;
   logic [fsdf_pkg::MAP_WORD_BITS-1:0]   seq_mask;
   logic                                 seen_hit;
   logic [fsdf_pkg::SEQ_W-1:0]           seq_dist;
   logic [fsdf_pkg::ADDR_W-1:0]          clr_base;

   fsdf_classify u_classify (
      .outer_ethertype (req_outer_ethertype),
      .word_at_sixteen (req_word_at_sixteen),
      .word_at_twenty  (req_word_at_twenty),
      .parse           (parse_new)
   );

   fsdf_seen_ram u_seen_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // word and bit of the sequence number in the map
   assign seq_word = parse_ff.seq[fsdf_pkg::SEQ_W-1:fsdf_pkg::BIT_W];
   assign seq_bit  = parse_ff.seq[fsdf_pkg::BIT_W-1:0];
   assign seq_mask = fsdf_pkg::MAP_WORD_BITS'(1) << seq_bit;
   assign seen_hit = ram_rd_data[seq_bit];

   // distance ahead of the window start, wraps in the sequence space
   assign seq_dist = parse_ff.seq - window_start_ff;

   // window start is always a multiple of the clear span, so word aligned
   assign clr_base = window_start_ff[fsdf_pkg::SEQ_W-1:fsdf_pkg::BIT_W];

   // map read only in the read state
   assign ram_rd_en   = (state_ff == ST_READ);
   assign ram_rd_addr = seq_word;

   always_comb begin
      state_in        = state_ff;
      init_cnt_in     = init_cnt_ff;
      clr_cnt_in      = clr_cnt_ff;
      window_start_in = window_start_ff;
      parse_in        = parse_ff;
      len_in          = len_ff;
      advance_in      = advance_ff;
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_seq_in      = rsp_seq_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = seq_word;
      ram_wr_data     = ram_rd_data | seq_mask;

      unique case (state_ff)
         ST_INIT: begin
            // zero one word per cycle after reset
            ram_wr_en   = 1'b1;
            ram_wr_addr = init_cnt_ff;
            ram_wr_data = '0;
            init_cnt_in = init_cnt_ff + fsdf_pkg::ADDR_W'(1);
            if (init_cnt_ff == fsdf_pkg::ADDR_W'(fsdf_pkg::MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               parse_in = parse_new;
               len_in   = req_frame_length;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // window check runs while the map word is fetched
            advance_in = (seq_dist > fsdf_pkg::SEQ_W'(fsdf_pkg::WINDOW_SPAN));
            state_in   = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (!parse_ff.has_tag) begin
               rsp_status_in = fsdf_pkg::STATUS_NOT_TAGGED;
               rsp_offset_in = '0;
               rsp_length_in = '0;
               rsp_seq_in    = '0;
            end else if (seen_hit) begin
               rsp_status_in = fsdf_pkg::STATUS_DUPLICATE;
               rsp_offset_in = parse_ff.hlen;
               rsp_length_in = '0;
               rsp_seq_in    = parse_ff.seq;
            end else begin
               // new sequence: set its bit
               ram_wr_en     = 1'b1;
               rsp_offset_in = parse_ff.hlen;
               rsp_seq_in    = parse_ff.seq;
               if (len_ff > fsdf_pkg::LEN_W'(parse_ff.hlen)) begin
                  rsp_status_in = fsdf_pkg::STATUS_FORWARD;
                  rsp_length_in = len_ff - fsdf_pkg::LEN_W'(parse_ff.hlen);
               end else begin
                  rsp_status_in = fsdf_pkg::STATUS_NO_PAYLOAD;
                  rsp_length_in = '0;
               end
               if (advance_ff) begin
                  clr_cnt_in = '0;
                  state_in   = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            // walk the oldest clear span, wrapping in the map
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_base + fsdf_pkg::ADDR_W'(clr_cnt_ff);
            ram_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + fsdf_pkg::CLR_CNT_W'(1);
            if (clr_cnt_ff == fsdf_pkg::CLR_CNT_W'(fsdf_pkg::CLEAR_WORDS - 1)) begin
               window_start_in = window_start_ff
                               + fsdf_pkg::SEQ_W'(fsdf_pkg::CLEAR_SPAN);
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         init_cnt_ff     <= '0;
         clr_cnt_ff      <= '0;
         window_start_ff <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         init_cnt_ff     <= init_cnt_in;
         clr_cnt_ff      <= clr_cnt_in;
         window_start_ff <= window_start_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      parse_ff      <= parse_in;
      len_ff        <= len_in;
      advance_ff    <= advance_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_length_ff <= rsp_length_in;
      rsp_seq_ff    <= rsp_seq_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_offset_ff;
   assign rsp_payload_length = rsp_length_ff;
   assign rsp_sequence_seen  = rsp_seq_ff;

   // an accepted beat always moves on to the map read
   `FSDF_ASSERT_NEXT(a_accept_reads, clock, reset, accept, state_ff == ST_READ, "accept without read")

   // every result beat follows a lookup
   `FSDF_ASSERT_NOW(a_rsp_after_lookup, clock, reset, rsp_strobe, $past(state_ff == ST_LOOKUP), "result without lookup")

   // a lookup write only ever comes from a new sequence number
   `FSDF_ASSERT_NEXT(a_set_is_new, clock, reset, ram_wr_en && state_ff == ST_LOOKUP, rsp_status_ff == fsdf_pkg::STATUS_FORWARD || rsp_status_ff == fsdf_pkg::STATUS_NO_PAYLOAD, "bit set on non-new beat")

   // the window only moves at the end of a clear walk
   `FSDF_ASSERT_NOW(a_window_moves, clock, reset, !$stable(window_start_ff), $past(state_ff == ST_CLEAR), "window moved outside clear")

endmodule

/* tb/tb_frame_sequence_duplicate_filter_top.sv */
// self-checking testbench for frame_sequence_duplicate_filter_top
// depends on fsdf_pkg and the filter rtl, reads nothing else
`timescale 1ns / 1ps

module tb_frame_sequence_duplicate_filter_top;

   import fsdf_pkg::*;

   // the map clearing of all 1024 words after reset, a clear walk of 128 words,
   // plus the longest sender gap, with a wide margin
   localparam int STALL_LIMIT  = 8192;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_BEATS = 1400;
   localparam int PRINT_CAP    = 60;

   // one header beat as presented on the req_ ports
   typedef struct {
      logic [SEQ_W-1:0] outer_ethertype;
      logic [SEQ_W-1:0] word_at_sixteen;
      logic [SEQ_W-1:0] word_at_twenty;
      logic [LEN_W-1:0] frame_length;
   } frame_hdr_type;

   // one result beat as expected on the rsp_ ports
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [OFF_W-1:0]    payload_offset;
      logic [LEN_W-1:0]    payload_length;
      logic [SEQ_W-1:0]    sequence_seen;
   } filter_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             start               = 1'b0;
   logic             busy;
   logic [SEQ_W-1:0] req_outer_ethertype = '0;
   logic [SEQ_W-1:0] req_word_at_sixteen = '0;
   logic [SEQ_W-1:0] req_word_at_twenty  = '0;
   logic [LEN_W-1:0] req_frame_length    = '0;

   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [OFF_W-1:0]    rsp_payload_offset;
   logic [LEN_W-1:0]    rsp_payload_length;
   logic [SEQ_W-1:0]    rsp_sequence_seen;

   frame_hdr_type     pending_headers[$];
   filter_result_type expected_results[$];
   frame_hdr_type     header_on_bus;

   // shadow of the block state: one bit per sequence number plus window start
   bit               seen_bits[SEQ_SPACE];
   logic [SEQ_W-1:0] window_base = '0;

   int   mismatch_count = 0;
   int   stall_cycles   = 0;
   logic timed_out      = 1'b0;

   // sender burst shaping
   int gap_left   = 0;
   int burst_left = 1;

   always #1 clock = ~clock;

   frame_sequence_duplicate_filter_top DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_outer_ethertype(req_outer_ethertype),
      .req_word_at_sixteen(req_word_at_sixteen),
      .req_word_at_twenty (req_word_at_twenty),
      .req_frame_length   (req_frame_length),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length),
      .rsp_sequence_seen  (rsp_sequence_seen)
   );

   // classify one header, look it up in the shadow map and update the map and
   // window exactly as the block does for a new sequence number
   function automatic filter_result_type filter_frame(frame_hdr_type hdr);
      filter_result_type res;
      logic              has_tag;
      logic [OFF_W-1:0]  hlen;
      logic [SEQ_W-1:0]  seq;
      logic [SEQ_W-1:0]  ahead;
      res.status         = STATUS_NOT_TAGGED;
      res.payload_offset = '0;
      res.payload_length = '0;
      res.sequence_seen  = '0;
      has_tag = 1'b1;
      hlen    = '0;
      seq     = '0;
      if (hdr.outer_ethertype == VLAN_ETHERTYPE && hdr.word_at_sixteen == TAG_ETHERTYPE) begin
         hlen = VLAN_TAG_HLEN;
         seq  = hdr.word_at_twenty;
      end else if (hdr.outer_ethertype == TAG_ETHERTYPE) begin
         hlen = TAG_HLEN;
         seq  = hdr.word_at_sixteen;
      end else begin
         // other ethertypes and vlan frames without the tag behind them
         has_tag = 1'b0;
      end
      if (has_tag) begin
         res.payload_offset = hlen;
         res.sequence_seen  = seq;
         if (seen_bits[seq]) begin
            res.status = STATUS_DUPLICATE;
         end else begin
            seen_bits[seq] = 1'b1;
            // distance ahead of the window start, modulo the sequence space
            ahead = seq - window_base;
            if (ahead > WINDOW_SPAN) begin
               for (int i = 0; i < CLEAR_SPAN; i++)
                  seen_bits[SEQ_W'(window_base + i)] = 1'b0;
               window_base = window_base + SEQ_W'(CLEAR_SPAN);
            end
            if (hdr.frame_length > LEN_W'(hlen)) begin
               res.status         = STATUS_FORWARD;
               res.payload_length = hdr.frame_length - LEN_W'(hlen);
            end else begin
               // new sequence but nothing left after the tag
               res.status = STATUS_NO_PAYLOAD;
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   task automatic queue_header(input logic [SEQ_W-1:0] outer, input logic [SEQ_W-1:0] w16,
                               input logic [SEQ_W-1:0] w20, input logic [LEN_W-1:0] len);
      frame_hdr_type hdr;
      hdr.outer_ethertype = outer;
      hdr.word_at_sixteen = w16;
      hdr.word_at_twenty  = w20;
      hdr.frame_length    = len;
      pending_headers.push_back(hdr);
   endtask

   // tagged frame, either directly or behind a vlan tag; the unused word of the direct form is random
   task automatic queue_tagged(input logic [SEQ_W-1:0] seq, input logic vlan,
                               input logic [LEN_W-1:0] len);
      if (vlan)
         queue_header(VLAN_ETHERTYPE, TAG_ETHERTYPE, seq, len);
      else
         queue_header(TAG_ETHERTYPE, seq, SEQ_W'($urandom), len);
   endtask

   // driver: one header beat per handshake, sent in bursts with random gaps
   always @(posedge clock) begin
      logic accepted;
      accepted = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (accepted)
            expected_results.push_back(filter_frame(header_on_bus));
         // the bus is free when nothing is offered or the offer was just taken
         if (!start || accepted) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_headers.size() > 0) begin
               header_on_bus = pending_headers.pop_front();
               req_outer_ethertype <= header_on_bus.outer_ethertype;
               req_word_at_sixteen <= header_on_bus.word_at_sixteen;
               req_word_at_twenty  <= header_on_bus.word_at_twenty;
               req_frame_length    <= header_on_bus.frame_length;
               start <= 1'b1;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  // a quarter of the bursts run straight into the next one
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                  burst_left = $urandom_range(1, 24);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe is one result beat, checked against the oldest expectation
   always @(posedge clock) begin
      filter_result_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (rsp_strobe !== 1'b1) begin
            report_mismatch("result strobe is unknown");
         end else if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: status %0d seq %0h",
                                      rsp_status, rsp_sequence_seen));
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d (seq %0h)",
                                         rsp_status, want.status, want.sequence_seen));
            if (rsp_payload_offset !== want.payload_offset)
               report_mismatch($sformatf("payload offset %0d, expected %0d (seq %0h)",
                                         rsp_payload_offset, want.payload_offset,
                                         want.sequence_seen));
            if (rsp_payload_length !== want.payload_length)
               report_mismatch($sformatf("payload length %0d, expected %0d (seq %0h)",
                                         rsp_payload_length, want.payload_length,
                                         want.sequence_seen));
            if (rsp_sequence_seen !== want.sequence_seen)
               report_mismatch($sformatf("sequence %0h, expected %0h",
                                         rsp_sequence_seen, want.sequence_seen));
         end
      end
   end

   // watchdog: counts cycles with work outstanding but no beat moving either way
   always @(posedge clock) begin
      if (reset || (pending_headers.size() == 0 && !start && expected_results.size() == 0)) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         timed_out <= 1'b1;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [SEQ_W-1:0] stream_seq;
      logic [LEN_W-1:0] len;
      int               roll;
      int               len_roll;

      // directed: forwarded, duplicate through both tag forms, short frames
      queue_tagged(16'd0, 1'b0, 14'd100);
      queue_tagged(16'd0, 1'b0, 14'd100);
      queue_tagged(16'd0, 1'b1, 14'd60);
      queue_tagged(16'd1, 1'b1, 14'd24);
      queue_tagged(16'd2, 1'b0, 14'd20);
      queue_tagged(16'd3, 1'b0, 14'd21);
      queue_tagged(16'd4, 1'b1, 14'd0);
      // exactly one window span ahead does not move the window, one more does
      queue_tagged(16'd16384, 1'b1, 14'd1000);
      queue_tagged(16'd16385, 1'b0, 14'h3FFF);
      // sequence zero was cleared by that advance, so it is new again
      queue_tagged(16'd0, 1'b0, 14'd64);
      // untagged: foreign ethertypes, vlan with the wrong inner ethertype
      queue_header(16'h0000, 16'h0000, 16'h0000, 14'd0);
      queue_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
      queue_header(VLAN_ETHERTYPE, 16'h0000, 16'd5, 14'd100);
      queue_header(VLAN_ETHERTYPE, 16'hF1C0, 16'd6, 14'd100);
      queue_header(16'hF1C0, 16'd7, 16'd7, 14'd100);
      queue_header(VLAN_ETHERTYPE, VLAN_ETHERTYPE, 16'd8, 14'd100);
      // outside the cleared range, still a duplicate
      queue_tagged(16'd16384, 1'b0, 14'd200);
      // push the window on six times, the sequence numbers wrapping past zero
      for (int k = 0; k < 6; k++)
         queue_tagged(SEQ_W'(32769 + 8192 * k), k[0], 14'd300);
      // top sequence number, new and then a duplicate
      queue_tagged(16'hFFFF, 1'b1, 14'h3FFF);
      queue_tagged(16'hFFFF, 1'b0, 14'h3FFF);

      // random: mostly an in-order stream with replicas, jumps and noise
      stream_seq = SEQ_W'($urandom);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         roll     = $urandom_range(0, 99);
         len_roll = $urandom_range(0, 99);
         if (len_roll < 15)
            len = LEN_W'($urandom_range(0, 26));
         else if (len_roll < 25)
            len = LEN_W'($urandom);
         else
            len = LEN_W'($urandom_range(60, 1518));
         if (roll < 55) begin
            // next in the stream, occasionally skipping a few
            queue_tagged(stream_seq, 1'($urandom_range(0, 1)), len);
            stream_seq = stream_seq
                       + SEQ_W'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : 1);
         end else if (roll < 75) begin
            // replica of a recent frame, usually a duplicate
            queue_tagged(stream_seq - SEQ_W'($urandom_range(1, 40)), 1'($urandom_range(0, 1)),
                         len);
         end else if (roll < 83) begin
            // jump ahead, at times far enough to push the window on
            stream_seq = stream_seq + SEQ_W'($urandom_range(1, 20000));
            queue_tagged(stream_seq, 1'($urandom_range(0, 1)), len);
         end else if (roll < 87) begin
            queue_tagged(SEQ_W'($urandom), 1'($urandom_range(0, 1)), len);
         end else if (roll < 93) begin
            queue_header(VLAN_ETHERTYPE, SEQ_W'($urandom), SEQ_W'($urandom), len);
         end else begin
            queue_header(SEQ_W'($urandom), SEQ_W'($urandom), SEQ_W'($urandom), len);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // wait for every header beat to go in and every result beat to come back
      while (!timed_out && !(pending_headers.size() == 0 && !start
                             && expected_results.size() == 0))
         @(negedge clock);

      if (timed_out) begin
         $display("Test completed with failures");
      end else begin
         // let a late clear walk finish and catch any stray result beat
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (mismatch_count == 0)
            $display("Test completed successfully");
         else
            $display("Test completed with failures");
      end
      $finish;
   end

endmodule
